>>> rtl/core/gtofd_pkg.sv
// ----------------------------------------------------------------------------
// gtofd_pkg
// Shared types and constants of the graph order and feedback detect block.
// ----------------------------------------------------------------------------
package gtofd_pkg;

  localparam int MaxNodes = 16;
  localparam int MaxEdges = 32;
  localparam int Sockets  = 8;
  localparam int NodeW    = $clog2(MaxNodes);
  localparam int EdgeW    = $clog2(MaxEdges);
  localparam int SockW    = $clog2(Sockets);

  localparam logic OpLoad    = 1'b0;
  localparam logic OpCompile = 1'b1;

  localparam logic KindNode = 1'b0;
  localparam logic KindEdge = 1'b1;

  localparam logic [1:0] ColWhite = 2'd0;
  localparam logic [1:0] ColGray  = 2'd1;
  localparam logic [1:0] ColBlack = 2'd2;

  typedef struct packed {
    logic             op;
    logic [NodeW-1:0] src_node;
    logic [SockW-1:0] src_socket;
    logic [NodeW-1:0] dst_node;
    logic [SockW-1:0] dst_socket;
    logic             src_is_mod;
    logic             dst_is_mod;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic [4:0]       entry_index;
    logic [NodeW-1:0] node_index;
    logic [NodeW-1:0] src_position;
    logic [SockW-1:0] out_src_socket;
    logic [NodeW-1:0] dst_position;
    logic [SockW-1:0] out_dst_socket;
    logic             feedback;
    logic [1:0]       conversion;
    logic [Sockets-1:0] connected_mask;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [NodeW-1:0] src;
    logic [SockW-1:0] ssock;
    logic [NodeW-1:0] dst;
    logic [SockW-1:0] dsock;
    logic             smod;
    logic             dmod;
  } edge_t;

  typedef enum logic [3:0] {
    StIdle, StClear, StRoot, StScanRd, StScan, StEdgeRd, StPos,
    StMask, StNodeRd, StNodeOut, StEdgeOutRd, StEdgeOut, StEdgeOut2, StWait
  } state_e;

endpackage

>>> rtl/core/gtofd_if.sv
// ----------------------------------------------------------------------------
// gtofd_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface gtofd_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/graph_topo_order_feedback_detect.sv
// ----------------------------------------------------------------------------
// graph_topo_order_feedback_detect
// Loads edges, then on compile runs an iterative depth-first search and emits
// nodes in topological order followed by remapped edges with feedback flags.
// ----------------------------------------------------------------------------
// channel   dir  payload
// in_if     in   op, edge ends, sockets, socket kinds
// out_if    out  node entry or edge entry, last on final item
// cfg       in   node_count
//
// a compile clears colours, masks and flags, tries each root in node order,
// scans the whole edge table for every node (pushing and popping the stack),
// writes node positions, builds socket masks over the edges, then emits node
// entries and usable edge entries, skipping the other edges; each result
// waits on out_if.ready. reset clears the edge count and node_count; the edge,
// stack, order and position tables are memories with registered reads.
module graph_topo_order_feedback_detect (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  gtofd_if.sink   in_if,
  gtofd_if.source out_if
);
  import gtofd_pkg::*;

  state_e state_q, state_d;
  logic [4:0] ncfg_q;
  logic [EdgeW:0] total_q, total_d;
  logic [NodeW:0] n;

  // memories
  edge_t edge_mem [MaxEdges];
  logic [MaxEdges-1:0] fb_q, fb_d;
  logic [NodeW-1:0] stk_node_mem [MaxNodes];
  logic [EdgeW:0] stk_next_mem [MaxNodes];
  logic [NodeW-1:0] post_mem [MaxNodes];
  logic [NodeW-1:0] pos_mem [MaxNodes];
  logic [1:0] col_q [MaxNodes];
  logic [1:0] col_d [MaxNodes];
  logic [Sockets-1:0] mask_q [MaxNodes];
  logic [Sockets-1:0] mask_d [MaxNodes];

  logic [EdgeW-1:0] e_raddr;
  edge_t e_rdata;
  logic e_we;
  logic [EdgeW-1:0] e_waddr;
  edge_t e_wdata;

  logic [NodeW:0] sp_q, sp_d, pc_q, pc_d, i_q, i_d;
  logic [NodeW-1:0] node_q, node_d;
  logic [EdgeW:0] c_q, c_d;
  logic [EdgeW:0] k_q, k_d;
  logic stk_we;
  logic [NodeW-1:0] stk_waddr, stk_node_w;
  logic [EdgeW:0] stk_next_w;
  logic [NodeW-1:0] stk_raddr, stk_node_r;
  logic [EdgeW:0] stk_next_r;
  logic post_we;
  logic [NodeW-1:0] post_waddr, post_wdata, post_raddr, post_r;
  logic pos_we;
  logic [NodeW-1:0] pos_waddr, pos_wdata, pos_raddr, pos_r;
  logic [NodeW-1:0] spos_q, spos_d;
  logic [EdgeW:0] use_q, use_d;
  out_item_t ob_q, ob_d;
  logic ov_q, ov_d;

  assign n = (ncfg_q > 5'(MaxNodes)) ? (NodeW+1)'(MaxNodes) : ncfg_q[NodeW:0];
  assign in_if.ready = (state_q == StIdle);
  assign out_if.valid = ov_q;
  assign out_if.data = ob_q;

  always_ff @(posedge clk_i) begin
    if (e_we) edge_mem[e_waddr] <= e_wdata;
    e_rdata <= edge_mem[e_raddr];
    if (stk_we) begin
      stk_node_mem[stk_waddr] <= stk_node_w;
      stk_next_mem[stk_waddr] <= stk_next_w;
    end
    stk_node_r <= stk_node_mem[stk_raddr];
    stk_next_r <= stk_next_mem[stk_raddr];
    if (post_we) post_mem[post_waddr] <= post_wdata;
    post_r <= post_mem[post_raddr];
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    pos_r <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ncfg_q  <= '0;
      total_q <= '0;
      ov_q    <= 1'b0;
      sp_q <= '0; pc_q <= '0; i_q <= '0; c_q <= '0; k_q <= '0;
      use_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) ncfg_q <= cfg_wdata_i;
      total_q <= total_d;
      ov_q <= ov_d;
      sp_q <= sp_d; pc_q <= pc_d; i_q <= i_d; c_q <= c_d; k_q <= k_d;
      use_q <= use_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fb_q <= fb_d;
    node_q <= node_d;
    spos_q <= spos_d;
    ob_q <= ob_d;
    col_q <= col_d;
    mask_q <= mask_d;
  end

  always_comb begin
    logic take;
    logic [NodeW-1:0] t;
    logic fin;
    logic [1:0] conv;
    state_d = state_q; total_d = total_q; ov_d = ov_q; ob_d = ob_q;
    fb_d = fb_q; node_d = node_q; spos_d = spos_q; use_d = use_q;
    sp_d = sp_q; pc_d = pc_q; i_d = i_q; c_d = c_q; k_d = k_q;
    col_d = col_q; mask_d = mask_q;
    e_we = 1'b0; e_waddr = total_q[EdgeW-1:0]; e_wdata = '0;
    e_raddr = c_q[EdgeW-1:0];
    stk_we = 1'b0; stk_waddr = '0; stk_node_w = '0; stk_next_w = '0;
    stk_raddr = '0;
    post_we = 1'b0; post_waddr = pc_q[NodeW-1:0]; post_wdata = node_q;
    post_raddr = '0;
    pos_we = 1'b0; pos_waddr = '0; pos_wdata = '0; pos_raddr = '0;
    take = 1'b0; t = e_rdata.dst; fin = 1'b0; conv = '0;
    if (ov_q && out_if.ready) ov_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_if.valid) begin
          if (in_if.data.op == OpCompile) begin
            state_d = StClear;
            i_d = '0; pc_d = '0; use_d = '0;
          end else if ({1'b0, in_if.data.src_node} < n &&
                       {1'b0, in_if.data.dst_node} < n &&
                       total_q < (EdgeW+1)'(MaxEdges)) begin
            e_we = 1'b1;
            e_wdata = '{src: in_if.data.src_node, ssock: in_if.data.src_socket,
                        dst: in_if.data.dst_node, dsock: in_if.data.dst_socket,
                        smod: in_if.data.src_is_mod, dmod: in_if.data.dst_is_mod};
            fb_d[total_q[EdgeW-1:0]] = 1'b0;
            total_d = total_q + 1'b1;
          end
        end
      end
      StClear: begin
        for (int j = 0; j < MaxNodes; j++) begin
          col_d[j] = ColWhite;
          mask_d[j] = '0;
        end
        fb_d = '0;
        state_d = StRoot;
      end
      StRoot: begin
        // try next root in node order
        if (i_q >= n) begin
          state_d = StPos; i_d = '0;
        end else if (col_q[i_q[NodeW-1:0]] != ColWhite) begin
          i_d = i_q + 1'b1;
        end else begin
          col_d[i_q[NodeW-1:0]] = ColGray;
          node_d = i_q[NodeW-1:0];
          c_d = '0; sp_d = (NodeW+1)'(1);
          stk_we = 1'b1; stk_waddr = '0; stk_node_w = i_q[NodeW-1:0];
          stk_next_w = '0;
          state_d = StScanRd;
        end
      end
      StScanRd: begin
        // node_q/c_q hold the top of stack; fetch edge c
        if (c_q >= total_q) begin
          col_d[node_q] = ColBlack;
          post_we = (pc_q < (NodeW+1)'(MaxNodes));
          if (post_we) pc_d = pc_q + 1'b1;
          sp_d = sp_q - 1'b1;
          if (sp_q == (NodeW+1)'(1)) begin
            state_d = StRoot; i_d = i_q + 1'b1;
          end else begin
            stk_raddr = 4'(sp_q - 2'd2);
            state_d = StEdgeRd;
          end
        end else begin
          e_raddr = c_q[EdgeW-1:0];
          state_d = StScan;
        end
      end
      StEdgeRd: begin
        // popped: restore parent from stack memory
        node_d = stk_node_r; c_d = stk_next_r;
        state_d = StScanRd;
      end
      StScan: begin
        take = (e_rdata.src == node_q) && ({1'b0, e_rdata.dst} < n);
        c_d = c_q + 1'b1;
        state_d = StScanRd;
        if (take) begin
          stk_we = 1'b1; stk_waddr = 4'(sp_q - 1'b1);
          stk_node_w = node_q; stk_next_w = c_q + 1'b1;
          if (col_q[t] == ColWhite) begin
            if (sp_q < (NodeW+1)'(MaxNodes)) begin
              col_d[t] = ColGray;
              stk_we = 1'b1;
              // save parent's resume point then push child
              sp_d = sp_q + 1'b1;
              node_d = t; c_d = '0;
              state_d = StWait;
            end
          end else if (col_q[t] == ColGray) begin
            fb_d[c_q[EdgeW-1:0]] = 1'b1;
          end
        end
      end
      StWait: begin
        stk_we = 1'b1; stk_waddr = 4'(sp_q - 1'b1);
        stk_node_w = node_q; stk_next_w = '0;
        state_d = StScanRd;
      end
      StPos: begin
        // position_of_node[post[pc-1-i]] = i, one node per pass through StPos and StNodeRd
        if (i_q >= pc_q) begin
          state_d = StMask; c_d = '0;
        end else begin
          post_raddr = 4'(pc_q - 1'b1 - i_q);
          state_d = StNodeRd;
        end
      end
      StNodeRd: begin
        pos_we = 1'b1; pos_waddr = post_r; pos_wdata = i_q[NodeW-1:0];
        i_d = i_q + 1'b1;
        state_d = StPos;
      end
      StMask: begin
        if (c_q >= total_q) begin
          i_d = '0; c_d = '0; state_d = StNodeOut;
        end else begin
          e_raddr = c_q[EdgeW-1:0];
          state_d = StEdgeOutRd; k_d = '0;
        end
      end
      StEdgeOutRd: begin
        // set destination socket masks and count usable edges so the final item can carry last
        if ({1'b0, e_rdata.src} < n && {1'b0, e_rdata.dst} < n) begin
          mask_d[e_rdata.dst][e_rdata.dsock] = 1'b1;
          use_d = use_q + 1'b1;
        end
        c_d = c_q + 1'b1;
        state_d = StMask;
      end
      StNodeOut: begin
        if (!ov_d) begin
          if (i_q < pc_q) begin
            post_raddr = 4'(pc_q - 1'b1 - i_q);
            state_d = StEdgeOut; k_d = '0;
          end else begin
            c_d = '0; state_d = StEdgeOut2; k_d = (EdgeW+1)'(1);
          end
        end
      end
      StEdgeOut: begin
        // post_r is the node at position i
        ob_d = '0;
        ob_d.kind = KindNode;
        ob_d.entry_index = 5'(i_q);
        ob_d.node_index = post_r;
        ob_d.connected_mask = mask_q[post_r];
        ob_d.last = (i_q == pc_q - 1'b1) && (use_q == '0);
        ov_d = 1'b1;
        i_d = i_q + 1'b1;
        state_d = StNodeOut;
      end
      StEdgeOut2: begin
        // phase k: 1 read edge, 2 read src pos, 3 read dst pos, 4 emit
        unique case (k_q[2:0])
          3'd1: begin
            if (c_q >= total_q) begin
              if (!ov_d) begin
                total_d = '0; state_d = StIdle;
              end
            end else if (!ov_d) begin
              e_raddr = c_q[EdgeW-1:0]; k_d = (EdgeW+1)'(2);
            end
          end
          3'd2: begin
            fin = ({1'b0, e_rdata.src} < n) && ({1'b0, e_rdata.dst} < n);
            if (!fin) begin
              c_d = c_q + 1'b1; k_d = (EdgeW+1)'(1);
            end else begin
              pos_raddr = e_rdata.src; k_d = (EdgeW+1)'(3);
            end
          end
          3'd3: begin
            spos_d = pos_r; pos_raddr = e_rdata.dst; k_d = (EdgeW+1)'(4);
          end
          default: begin
            conv = {e_rdata.smod, e_rdata.dmod};
            ob_d = '0;
            ob_d.kind = KindEdge;
            ob_d.entry_index = 5'(c_q);
            ob_d.src_position = spos_q;
            ob_d.out_src_socket = e_rdata.ssock;
            ob_d.dst_position = pos_r;
            ob_d.out_dst_socket = e_rdata.dsock;
            ob_d.feedback = fb_q[c_q[EdgeW-1:0]];
            ob_d.conversion = (conv == 2'b01) ? 2'd1 : (conv == 2'b10) ? 2'd2 :
                              (conv == 2'b11) ? 2'd3 : 2'd0;
            ob_d.last = (use_q == (EdgeW+1)'(1));
            ov_d = 1'b1;
            use_d = use_q - 1'b1;
            c_d = c_q + 1'b1; k_d = (EdgeW+1)'(1);
          end
        endcase
      end
      default: state_d = StIdle;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_if.ready) |=> ov_q)
    else $error("item dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && $past(state_q) != StIdle && $past(state_q) != StClear)
      |-> total_q == '0 || $past(state_q) == StIdle)
    else $error("edge table not emptied by compile");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= (EdgeW+1)'(MaxEdges))
    else $error("edge count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= (NodeW+1)'(MaxNodes) && sp_q <= (NodeW+1)'(MaxNodes))
    else $error("stack or order overflow");

endmodule

>>> test/graph_topo_order_feedback_detect_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_topo_order_feedback_detect_test
// Loads random and directed edge sets, compiles them under several node
// counts and idle patterns, and checks every node and edge entry against an
// in-bench depth-first search predictor.
// ----------------------------------------------------------------------------
module graph_topo_order_feedback_detect_test;
  import gtofd_pkg::*;

  localparam int CycleLimit = 400000;

  typedef struct {
    logic [NodeW-1:0] src;
    logic [SockW-1:0] ssock;
    logic [NodeW-1:0] dst;
    logic [SockW-1:0] dsock;
    logic smod;
    logic dmod;
  } loaded_edge_t;

  class entry_board;
    out_item_t pending[$];
    int errors;
    int seen;
    int node_cfg;
    loaded_edge_t edges[$];

    function new();
      errors = 0;
      seen = 0;
      node_cfg = 0;
    endfunction

    // work out the results of one accepted input item
    function void note_item(in_item_t it);
      int n;
      loaded_edge_t le;
      n = (node_cfg > MaxNodes) ? MaxNodes : node_cfg;
      if (it.op == OpLoad) begin
        if (it.src_node < n && it.dst_node < n && edges.size() < MaxEdges) begin
          le = '{it.src_node, it.src_socket, it.dst_node,
                 it.dst_socket, it.src_is_mod, it.dst_is_mod};
          edges = {edges, le};
        end
      end else begin
        run_walk(n);
      end
    endfunction

    function void run_walk(int n);
      logic [1:0] colour[MaxNodes];
      int stk_node[MaxNodes];
      int stk_next[MaxNodes];
      int post[$];
      int pos_of[MaxNodes];
      logic [Sockets-1:0] mask[MaxNodes];
      bit fb[$];
      int sp, top, nd, c, t, cnt;
      out_item_t r;
      out_item_t run[$];
      for (int i = 0; i < MaxNodes; i++) begin
        colour[i] = ColWhite;
        mask[i] = '0;
        pos_of[i] = 0;
      end
      foreach (edges[e]) fb = {fb, 1'b0};
      for (int i = 0; i < n; i++) begin
        if (colour[i] != ColWhite) continue;
        colour[i] = ColGray;
        stk_node[0] = i;
        stk_next[0] = 0;
        sp = 1;
        while (sp > 0) begin
          top = sp - 1;
          nd = stk_node[top];
          c = stk_next[top];
          while (c < edges.size() && !(edges[c].src == nd && edges[c].dst < n)) c++;
          if (c < edges.size()) begin
            t = edges[c].dst;
            stk_next[top] = c + 1;
            if (colour[t] == ColWhite) begin
              if (sp < MaxNodes) begin
                colour[t] = ColGray;
                stk_node[sp] = t;
                stk_next[sp] = 0;
                sp++;
              end
            end else if (colour[t] == ColGray) begin
              fb[c] = 1;
            end
          end else begin
            colour[nd] = ColBlack;
            if (post.size() < MaxNodes) post = {post, nd};
            sp--;
          end
        end
      end
      cnt = post.size();
      for (int i = 0; i < cnt; i++) pos_of[post[cnt-1-i]] = i;
      foreach (edges[e])
        if (edges[e].src < n && edges[e].dst < n) mask[edges[e].dst][edges[e].dsock] = 1'b1;
      for (int i = 0; i < cnt; i++) begin
        r = '0;
        r.kind = KindNode;
        r.entry_index = 5'(i);
        r.node_index = NodeW'(post[cnt-1-i]);
        r.connected_mask = mask[post[cnt-1-i]];
        run = {run, r};
      end
      foreach (edges[e]) begin
        if (edges[e].src >= n || edges[e].dst >= n) continue;
        r = '0;
        r.kind = KindEdge;
        r.entry_index = 5'(e);
        r.src_position = NodeW'(pos_of[edges[e].src]);
        r.out_src_socket = edges[e].ssock;
        r.dst_position = NodeW'(pos_of[edges[e].dst]);
        r.out_dst_socket = edges[e].dsock;
        r.feedback = fb[e];
        r.conversion = {edges[e].smod, edges[e].dmod} == 2'b01 ? 2'd1 :
                       {edges[e].smod, edges[e].dmod} == 2'b10 ? 2'd2 :
                       {edges[e].smod, edges[e].dmod} == 2'b11 ? 2'd3 : 2'd0;
        run = {run, r};
      end
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[k]) pending = {pending, run[k]};
      edges.delete();
    endfunction

    function void check_entry(out_item_t got);
      out_item_t want;
      seen++;
      if (pending.size() == 0) begin
        report_mismatch("entry with nothing pending", got, got);
        return;
      end
      want = pending.pop_front();
      if (got.kind != want.kind) report_mismatch("kind", got, want);
      if (got.entry_index != want.entry_index) report_mismatch("entry_index", got, want);
      if (got.node_index != want.node_index) report_mismatch("node_index", got, want);
      if (got.src_position != want.src_position) report_mismatch("src_position", got, want);
      if (got.out_src_socket != want.out_src_socket) report_mismatch("src_socket", got, want);
      if (got.dst_position != want.dst_position) report_mismatch("dst_position", got, want);
      if (got.out_dst_socket != want.out_dst_socket) report_mismatch("dst_socket", got, want);
      if (got.feedback != want.feedback) report_mismatch("feedback", got, want);
      if (got.conversion != want.conversion) report_mismatch("conversion", got, want);
      if (got.connected_mask != want.connected_mask) report_mismatch("mask", got, want);
      if (got.last != want.last) report_mismatch("last", got, want);
    endfunction

    function void report_mismatch(string what, out_item_t got, out_item_t want);
      errors++;
      if (errors <= 30)
        $display("mismatch %s: got %h want %h", what, got, want);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [4:0] cfg_wdata_i;
  gtofd_if #(.payload_t(in_item_t)) in_if ();
  gtofd_if #(.payload_t(out_item_t)) out_if ();

  graph_topo_order_feedback_detect dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_if(in_if), .out_if(out_if)
  );

  entry_board board;
  int send_idle_pct;
  int recv_stall_pct;
  int cycles;
  int items_sent;
  int compiles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout with %0d entries pending", board.pending.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver: sample at rising edge, change ready at falling edge
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_if.valid && out_if.ready) board.check_entry(out_if.data);

  // valid stays up after the accepting edge; the next call or wait_drain
  // decides what it becomes
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    board.note_item(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    // a compile with no entries may still be clearing
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_count(int value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= 5'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.node_cfg = value;
  endtask

  task automatic load_edge(int s, int ss, int d, int ds, bit sm, bit dm);
    in_item_t it;
    it.op = OpLoad;
    it.src_node = NodeW'(s);
    it.src_socket = SockW'(ss);
    it.dst_node = NodeW'(d);
    it.dst_socket = SockW'(ds);
    it.src_is_mod = sm;
    it.dst_is_mod = dm;
    send_item(it);
  endtask

  task automatic compile_graph();
    in_item_t it;
    it = in_item_t'($urandom);
    it.op = OpCompile;
    send_item(it);
    compiles++;
  endtask

  // one random graph: mostly in-range edges, some drawn over all node indices
  task automatic random_graph(int n, int edges);
    int lim;
    lim = (n > MaxNodes) ? MaxNodes : n;
    for (int k = 0; k < edges; k++) begin
      if (lim > 0 && $urandom_range(9) != 0)
        load_edge($urandom_range(lim-1), $urandom_range(7), $urandom_range(lim-1),
                  $urandom_range(7), $urandom_range(1), $urandom_range(1));
      else
        load_edge($urandom_range(15), $urandom_range(7), $urandom_range(15),
                  $urandom_range(7), $urandom_range(1), $urandom_range(1));
    end
    compile_graph();
  endtask

  initial begin
    int n;
    board = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_sent = 0;
    compiles = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty compile with zero nodes, dropped edge
    load_edge(0, 0, 0, 0, 0, 0);
    compile_graph();
    wait_drain();
    // small cycle with all conversions, self loop, out of range node
    write_count(4);
    load_edge(0, 7, 1, 0, 0, 0);
    load_edge(1, 1, 2, 7, 0, 1);
    load_edge(2, 2, 0, 3, 1, 0);
    load_edge(3, 3, 3, 4, 1, 1);
    load_edge(0, 0, 9, 0, 0, 0);
    load_edge(15, 0, 2, 0, 1, 1);
    compile_graph();
    wait_drain();
    // shrink node count after loading
    write_count(16);
    load_edge(15, 5, 14, 6, 1, 0);
    load_edge(1, 0, 15, 1, 0, 1);
    load_edge(2, 0, 3, 2, 0, 0);
    wait_drain();
    write_count(3);
    compile_graph();
    wait_drain();
    // count above maximum, table overflow
    write_count(31);
    for (int k = 0; k < 34; k++)
      load_edge(k % 16, k % 8, (k * 7 + 1) % 16, (k * 3) % 8, k[0], k[1]);
    compile_graph();
    wait_drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 63 : 13) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 63 : 13) : 0;
      for (int g = 0; g < 5; g++) begin
        case ($urandom_range(5))
          0: n = 1;
          1: n = 16;
          2: n = $urandom_range(17, 31);
          default: n = $urandom_range(2, 8);
        endcase
        write_count(n);
        random_graph(n, $urandom_range(1, 14));
        wait_drain();
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drain();

    $display("ran %0d input items over %0d compiles, %0d entries checked",
             items_sent, compiles, board.seen);
    $display("node counts 0 to 31, overflow, dropped edges and idle mixes covered");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

>>> graph_topo_order_feedback_detect.f
rtl/core/gtofd_pkg.sv
rtl/core/gtofd_if.sv
rtl/core/graph_topo_order_feedback_detect.sv
test/graph_topo_order_feedback_detect_test.sv
